>>> design/acfd_pkg.sv
// Shared types, codes and the CRC-16 byte update for the access control frame decoder.
// No dependencies.
`default_nettype none
package acfd_pkg;

  localparam logic [7:0]  SOM_VALUE    = 8'h53;
  localparam logic [15:0] CRC_INIT     = 16'h1D0F;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] HDR_LEN      = 16'd5;
  localparam logic [16:0] MIN_LEN_SUM  = 17'd7;
  localparam logic [16:0] MIN_LEN_CRC  = 17'd8;
  localparam logic [7:0]  BLK_MIN      = 8'd2;
  localparam logic [15:0] MAC_LEN      = 16'd4;
  localparam logic [7:0]  MAC_TYPE_LO  = 8'h15;
  localparam logic [7:0]  MAC_TYPE_HI  = 8'h18;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  localparam int CTRL_CRC_BIT = 2;
  localparam int CTRL_SCB_BIT = 3;

  localparam logic [15:0] MAX_LEN_RESET  = 16'd1024;
  localparam logic [7:0]  CTRL_MASK_RESET = 8'h70;

  localparam logic CFG_IDX_MAX_LEN   = 1'b0;
  localparam logic CFG_IDX_CTRL_MASK = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_SECURITY = 2'd1,
    KIND_VERDICT  = 2'd2
  } item_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_BAD_SOM   = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_CTRL  = 3'd4,
    ST_BAD_PLD   = 3'd5,
    ST_BAD_CRC   = 3'd6,
    ST_BAD_SUM   = 3'd7
  } status_t;

  typedef struct packed {
    logic [15:0] max_frame_length;
    logic [7:0]  reserved_ctrl_mask;
  } cfg_t;

  typedef struct packed {
    item_kind_t  item_kind;
    logic [7:0]  out_byte;
    status_t     status;
    logic [6:0]  address;
    logic        reply;
    logic [1:0]  sequence_res;
    logic        crc_used;
    logic        security_present;
    logic [7:0]  security_type;
    logic [7:0]  command_code;
    logic [15:0] payload_length;
    logic [31:0] mac_value;
  } result_t;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> design/access_control_frame_decoder.sv
// Top level of the access control frame decoder: input register, config registers,
// result register. Depends on acfd_pkg and acfd_parse.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------------
//   in_      | input     | in_valid / in_stall  | data_byte, last_byte
//   out_     | output    | out_valid / out_stall| item_kind .. mac_value (12 fields)
//   cfg_     | input     | cfg_write_en         | cfg_index, cfg_data
//
// One byte per cycle while the output is not stalled.
// The byte-wide CRC update and the verdict compares sit between input and result register.
// Reset (synchronous) clears frame state, sets CRC to 0x1D0F and the config registers
// to 1024 and 0x70.
// With the result register stalled, one more byte is taken into the input register.
`default_nettype none
module access_control_frame_decoder
  import acfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_item_kind,
  output logic [7:0]       out_out_byte,
  output logic [2:0]       out_status,
  output logic [6:0]       out_address,
  output logic             out_reply,
  output logic [1:0]       out_sequence_res,
  output logic             out_crc_used,
  output logic             out_security_present,
  output logic [7:0]       out_security_type,
  output logic [7:0]       out_command_code,
  output logic [15:0]      out_payload_length,
  output logic [31:0]      out_mac_value,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t        cfg_r;
  logic        s1_valid_r;
  logic [7:0]  s1_data_r;
  logic        s1_last_r;
  logic        out_valid_r;
  result_t     out_res_r;
  result_t     res;
  logic        res_valid;
  logic        advance;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  acfd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .cfg       (cfg_r),
    .res       (res),
    .res_valid (res_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_length   <= MAX_LEN_RESET;
      cfg_r.reserved_ctrl_mask <= CTRL_MASK_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_IDX_MAX_LEN:   cfg_r.max_frame_length <= cfg_data;
        CFG_IDX_CTRL_MASK: cfg_r.reserved_ctrl_mask <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // result register: loads on a transaction-producing byte, drains when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_item_kind        = out_res_r.item_kind;
  assign out_out_byte         = out_res_r.out_byte;
  assign out_status           = out_res_r.status;
  assign out_address          = out_res_r.address;
  assign out_reply            = out_res_r.reply;
  assign out_sequence_res     = out_res_r.sequence_res;
  assign out_crc_used         = out_res_r.crc_used;
  assign out_security_present = out_res_r.security_present;
  assign out_security_type    = out_res_r.security_type;
  assign out_command_code     = out_res_r.command_code;
  assign out_payload_length   = out_res_r.payload_length;
  assign out_mac_value        = out_res_r.mac_value;

endmodule
`default_nettype wire

>>> design/acfd_parse.sv
// Frame state and per-byte decode: header capture, CRC/checksum, emission and verdict.
// Depends on acfd_pkg.
`default_nettype none
module acfd_parse
  import acfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire cfg_t       cfg,
  output result_t         res,
  output logic            res_valid
);

  logic [15:0] count_r, count_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [15:0] length_r, length_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  blen_r, blen_nxt;
  logic [7:0]  btype_r, btype_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [31:0] mac_r, mac_nxt;
  logic [15:0] tail_r, tail_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  sum_r, sum_nxt;

  // state after this byte, before the end-of-frame clear
  logic [7:0]  u_first, u_addr, u_ctrl, u_blen, u_btype, u_code, u_sum;
  logic [15:0] u_length, u_tail, u_crc;
  logic [31:0] u_mac;

  logic [15:0] idx, pend, cidx, msz, n_int;
  logic        has_blk, has_mac;
  logic        emit_pld, emit_sec;
  logic [1:0]  mac_sel;

  // verdict terms
  logic [16:0] vlen, cur, need, blk_need, pl;
  status_t     vstat;

  always_comb begin
    idx      = count_r;
    u_first  = first_r;
    u_addr   = addr_r;
    u_length = length_r;
    u_ctrl   = ctrl_r;
    u_blen   = blen_r;
    u_btype  = btype_r;
    u_code   = code_r;
    u_mac    = mac_r;
    u_tail   = tail_r;
    u_crc    = crc_r;
    u_sum    = sum_r;
    emit_pld = 1'b0;
    emit_sec = 1'b0;
    mac_sel  = 2'd0;

    case (idx)
      16'd0:   u_first = data_byte;
      16'd1:   u_addr = data_byte;
      16'd2:   u_length = {length_r[15:8], data_byte};
      16'd3:   u_length = {data_byte, length_r[7:0]};
      16'd4:   u_ctrl = data_byte;
      default: ;
    endcase

    has_blk = u_ctrl[CTRL_SCB_BIT];
    n_int   = u_ctrl[CTRL_CRC_BIT] ? 16'd2 : 16'd1;
    pend    = (u_length >= n_int) ? (u_length - n_int) : 16'd0;

    if (idx >= HDR_LEN) begin
      if (has_blk && idx == 16'd5) u_blen = data_byte;
      if (has_blk && idx == 16'd6) u_btype = data_byte;
    end

    has_mac = has_blk && u_btype >= MAC_TYPE_LO && u_btype <= MAC_TYPE_HI;
    cidx    = has_blk ? (HDR_LEN + {8'd0, u_blen}) : HDR_LEN;
    msz     = has_mac ? MAC_LEN : 16'd0;

    if (idx < HDR_LEN || idx < pend) begin
      u_crc = crc_update(crc_r, data_byte);
      u_sum = sum_r + data_byte;
    end

    if (idx >= HDR_LEN) begin
      if (idx == pend) u_tail = {tail_r[15:8], data_byte};
      if ({1'b0, idx} == {1'b0, pend} + 17'd1) u_tail = {data_byte, tail_r[7:0]};
      if (!has_blk || u_blen >= BLK_MIN) begin
        if (idx == cidx) u_code = data_byte;
        emit_sec = has_blk && idx >= (HDR_LEN + 16'd2) && idx < cidx && idx < pend;
        emit_pld = idx > cidx && pend >= msz && idx < (pend - msz);
        if (has_mac && pend >= MAC_LEN && idx >= (pend - MAC_LEN) && idx < pend) begin
          mac_sel = 2'(idx - (pend - MAC_LEN));
          u_mac   = mac_r | ({24'd0, data_byte} << {mac_sel, 3'b000});
        end
      end
    end
  end

  // verdict over the updated state
  always_comb begin
    vlen     = {1'b0, idx} + 17'd1;
    cur      = has_blk ? (17'(HDR_LEN) + {9'd0, u_blen}) : 17'(HDR_LEN);
    blk_need = 17'(HDR_LEN) + {9'd0, u_blen} + 17'd1 + {1'b0, n_int};
    need     = cur + 17'd1 + {1'b0, n_int};
    pl       = vlen - {1'b0, n_int} - cur - 17'd1;
    if (has_mac) pl = pl - 17'(MAC_LEN);

    if (vlen < MIN_LEN_SUM) begin
      vstat = ST_TRUNCATED;
    end else if (u_first != SOM_VALUE) begin
      vstat = ST_BAD_SOM;
    end else if ({1'b0, u_length} != vlen || u_length > cfg.max_frame_length) begin
      vstat = ST_BAD_LEN;
    end else if ((u_ctrl & cfg.reserved_ctrl_mask) != 8'd0) begin
      vstat = ST_BAD_CTRL;
    end else if (vlen < (u_ctrl[CTRL_CRC_BIT] ? MIN_LEN_CRC : MIN_LEN_SUM)) begin
      vstat = ST_TRUNCATED;
    end else if (has_blk && (17'(HDR_LEN) + 17'(BLK_MIN)) > vlen) begin
      vstat = ST_TRUNCATED;
    end else if (has_blk && u_blen < BLK_MIN) begin
      vstat = ST_BAD_LEN;
    end else if (has_blk && blk_need > vlen) begin
      vstat = ST_BAD_LEN;
    end else if (need > vlen) begin
      vstat = ST_TRUNCATED;
    end else if (has_mac && (vlen - {1'b0, n_int} - cur - 17'd1) < 17'(MAC_LEN)) begin
      vstat = ST_BAD_PLD;
    end else if (u_ctrl[CTRL_CRC_BIT]) begin
      vstat = (u_tail != u_crc) ? ST_BAD_CRC : ST_OK;
    end else begin
      vstat = (u_tail[7:0] != (8'd0 - u_sum)) ? ST_BAD_SUM : ST_OK;
    end
  end

  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (last_byte) begin
      res_valid      = 1'b1;
      res.item_kind  = KIND_VERDICT;
      res.status     = vstat;
      if (vstat == ST_OK) begin
        res.address          = u_addr[6:0];
        res.reply            = u_addr[7];
        res.sequence_res     = u_ctrl[1:0];
        res.crc_used         = u_ctrl[CTRL_CRC_BIT];
        res.security_present = has_blk;
        res.security_type    = has_blk ? u_btype : 8'd0;
        res.command_code     = u_code;
        res.payload_length   = pl[15:0];
        res.mac_value        = has_mac ? u_mac : 32'd0;
      end
    end else if (emit_pld || emit_sec) begin
      res_valid     = 1'b1;
      res.item_kind = emit_pld ? KIND_PAYLOAD : KIND_SECURITY;
      res.out_byte  = data_byte;
    end
  end

  always_comb begin
    if (last_byte) begin
      count_nxt  = 16'd0;
      first_nxt  = 8'd0;
      addr_nxt   = 8'd0;
      length_nxt = 16'd0;
      ctrl_nxt   = 8'd0;
      blen_nxt   = 8'd0;
      btype_nxt  = 8'd0;
      code_nxt   = 8'd0;
      mac_nxt    = 32'd0;
      tail_nxt   = 16'd0;
      crc_nxt    = CRC_INIT;
      sum_nxt    = 8'd0;
    end else begin
      count_nxt  = (count_r != COUNT_MAX) ? count_r + 16'd1 : count_r;
      first_nxt  = u_first;
      addr_nxt   = u_addr;
      length_nxt = u_length;
      ctrl_nxt   = u_ctrl;
      blen_nxt   = u_blen;
      btype_nxt  = u_btype;
      code_nxt   = u_code;
      mac_nxt    = u_mac;
      tail_nxt   = u_tail;
      crc_nxt    = u_crc;
      sum_nxt    = u_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 16'd0;
      first_r  <= 8'd0;
      addr_r   <= 8'd0;
      length_r <= 16'd0;
      ctrl_r   <= 8'd0;
      blen_r   <= 8'd0;
      btype_r  <= 8'd0;
      code_r   <= 8'd0;
      mac_r    <= 32'd0;
      tail_r   <= 16'd0;
      crc_r    <= CRC_INIT;
      sum_r    <= 8'd0;
    end else if (step) begin
      count_r  <= count_nxt;
      first_r  <= first_nxt;
      addr_r   <= addr_nxt;
      length_r <= length_nxt;
      ctrl_r   <= ctrl_nxt;
      blen_r   <= blen_nxt;
      btype_r  <= btype_nxt;
      code_r   <= code_nxt;
      mac_r    <= mac_nxt;
      tail_r   <= tail_nxt;
      crc_r    <= crc_nxt;
      sum_r    <= sum_nxt;
    end
  end

endmodule
`default_nettype wire
